// ===== sv/pidtaw_pkg.sv =====
package pidtaw_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int DATA_W   = 32;
    localparam int PERIOD_W = 20;
    localparam int LIMIT_W  = 30;
    localparam int IDX_W    = 3;
    localparam int ACC_W    = 40;
    localparam int TENT_W   = 42;
    localparam int MUL_W    = 34;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DIV_W    = 54;
    localparam int SUM_W    = 60;
    localparam int CNT_W    = $clog2(DIV_W + 1);

    // division by 1e6 through a reciprocal: magnitude below 2^51, quotient below 2^33
    localparam int MAG_W     = 51;
    localparam int QUO_W     = 33;
    localparam int REC_LO    = 18;
    localparam int REC_SHIFT = 34;

    localparam logic [PERIOD_W-1:0] US_PER_S  = PERIOD_W'(1000000);
    // floor(2^52 / 1e6)
    localparam logic [QUO_W-1:0]    US_RECIP  = 33'd4503599627;
    localparam longint              LIMIT_MAX = 64'd1073741823;

    localparam logic [IDX_W-1:0] REG_KP     = 3'd0;
    localparam logic [IDX_W-1:0] REG_KI     = 3'd1;
    localparam logic [IDX_W-1:0] REG_KD     = 3'd2;
    localparam logic [IDX_W-1:0] REG_PERIOD = 3'd3;
    localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd4;

    typedef enum logic [2:0] {
        MS_P,
        MS_DIFF,
        MS_D,
        MS_AVG,
        MS_IT,
        MS_IU,
        MS_REC,
        MS_QM
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_start;
        logic     wr_p;
        logic     wr_r;
        logic     wr_d;
        logic     wr_mag;
        logic     wr_q;
        logic     wr_tent;
        logic     wr_acc;
        logic     wr_fin;
        logic     wr_clr;
        logic     wr_zero;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic period_zero;
    } dp_stat_t;

    // 1000.0 in fixed point, saturated to the limit register width
    function automatic logic [LIMIT_W-1:0] limit_reset(input int frac);
        longint v;
        v = 64'd1000 << frac;
        if (v > LIMIT_MAX)
        begin
            v = LIMIT_MAX;
        end
        return v[LIMIT_W-1:0];
    endfunction

endpackage

// ===== sv/pidtaw_div.sv =====
module pidtaw_div
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [pidtaw_pkg::DIV_W-1:0]     dividend,
    input  logic        [pidtaw_pkg::PERIOD_W-1:0]  divisor,
    output logic                                    busy,
    output logic signed [pidtaw_pkg::DIV_W-1:0]     quotient
);

    logic [pidtaw_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [pidtaw_pkg::DIV_W-1:0]    work_reg, work_next;
    logic [pidtaw_pkg::PERIOD_W-1:0] rem_reg, rem_next;
    logic [pidtaw_pkg::PERIOD_W-1:0] dsr_reg, dsr_next;
    logic                            neg_reg, neg_next;
    logic [pidtaw_pkg::PERIOD_W:0]   rem_sh;
    logic [pidtaw_pkg::PERIOD_W:0]   rem_sub;

    assign busy     = (cnt_reg != '0);
    assign quotient = neg_reg ? -$signed(work_reg) : $signed(work_reg);

    always_comb
    begin
        rem_sh    = {rem_reg, work_reg[pidtaw_pkg::DIV_W-1]};
        rem_sub   = rem_sh - {1'b0, dsr_reg};
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            // divide magnitudes, sign restored at the end (truncates toward zero)
            neg_next  = dividend[pidtaw_pkg::DIV_W-1];
            work_next = dividend[pidtaw_pkg::DIV_W-1] ? unsigned'(-dividend)
                                                      : unsigned'(dividend);
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = pidtaw_pkg::CNT_W'(pidtaw_pkg::DIV_W);
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next  = rem_sub[pidtaw_pkg::PERIOD_W-1:0];
                work_next = {work_reg[pidtaw_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[pidtaw_pkg::PERIOD_W-1:0];
                work_next = {work_reg[pidtaw_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        neg_reg  <= neg_next;
    end

endmodule

// ===== sv/pidtaw_dp.sv =====
module pidtaw_dp
#(
    parameter int FRAC_BITS = pidtaw_pkg::FRAC_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pidtaw_pkg::dp_cmd_t                   cmd,
    output pidtaw_pkg::dp_stat_t                  stat,
    input  logic                                  cfg_valid,
    input  logic [pidtaw_pkg::IDX_W-1:0]          cfg_index,
    input  logic [pidtaw_pkg::DATA_W-1:0]         cfg_data,
    input  logic signed [pidtaw_pkg::DATA_W-1:0]  err_sample,
    output logic signed [pidtaw_pkg::DATA_W-1:0]  drive,
    output logic                                  limited
);

    localparam int DW = pidtaw_pkg::DATA_W;
    localparam int SW = pidtaw_pkg::SUM_W;
    localparam int TW = pidtaw_pkg::TENT_W;
    localparam int MW = pidtaw_pkg::MUL_W;
    localparam int AW = pidtaw_pkg::ACC_W;
    localparam int QW = pidtaw_pkg::QUO_W;
    localparam int XW = pidtaw_pkg::DIV_W;
    localparam int QH = pidtaw_pkg::REC_SHIFT + QW - 1;
    localparam logic signed [TW-1:0] TENT_MAX = TW'(64'd4294967295);
    localparam logic signed [pidtaw_pkg::DIV_W-1:0] R_MAX = pidtaw_pkg::DIV_W'(64'h7FFFFFFF);

    // configuration
    logic signed [DW-1:0]                   kp_reg, ki_reg, kd_reg;
    logic [pidtaw_pkg::PERIOD_W-1:0]        period_reg;
    logic [pidtaw_pkg::LIMIT_W-1:0]         limit_reg;

    // controller state and working values
    logic signed [AW-1:0]                   acc_reg, acc_next;
    logic signed [DW-1:0]                   last_reg;
    logic signed [DW-1:0]                   e_reg;
    logic signed [SW-1:0]                   p_reg, d_reg;
    logic signed [DW-1:0]                   r_reg, r_next;
    logic signed [TW-1:0]                   tent_reg;
    logic signed [pidtaw_pkg::PROD_W-1:0]   prod_reg;
    logic signed [DW-1:0]                   drive_reg, drive_next;
    logic                                   limited_reg, limited_next;
    logic [XW-1:0]                          mag_reg;
    logic                                   sgn_reg;
    logic [QW-1:0]                          q_reg;

    logic signed [DW:0]                     diff, esum;
    logic signed [TW-1:0]                   tent_sat;
    logic signed [MW-1:0]                   mul_a, mul_b;
    logic signed [pidtaw_pkg::PROD_W-1:0]   prod_sh;
    logic signed [SW-1:0]                   sh_t;
    logic signed [SW-1:0]                   lim_s;
    logic signed [SW-1:0]                   u_sum;
    logic signed [TW-1:0]                   ilim;
    logic signed [TW-1:0]                   acc_sel;
    logic signed [TW-1:0]                   tent_calc;
    logic                                   keep_tent;
    logic                                   div_busy;
    logic signed [pidtaw_pkg::DIV_W-1:0]    quot;
    logic [XW-1:0]                          mag_val;
    logic [XW-1:0]                          rem;
    logic                                   q_inc;
    logic signed [TW-1:0]                   q_ext;
    logic signed [TW-1:0]                   inc_ext;

    pidtaw_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg[pidtaw_pkg::DIV_W-1:0]),
        .divisor  (period_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    assign stat.div_busy    = div_busy;
    assign stat.period_zero = (period_reg == '0);
    assign drive            = drive_reg;
    assign limited          = limited_reg;

    always_comb
    begin
        diff  = $signed({e_reg[DW-1], e_reg}) - $signed({last_reg[DW-1], last_reg});
        esum  = $signed({e_reg[DW-1], e_reg}) + $signed({last_reg[DW-1], last_reg});

        if (tent_reg > TENT_MAX)
        begin
            tent_sat = TENT_MAX;
        end
        else if (tent_reg < -TENT_MAX)
        begin
            tent_sat = -TENT_MAX;
        end
        else
        begin
            tent_sat = tent_reg;
        end

        case (cmd.mul_sel)
            pidtaw_pkg::MS_P:
            begin
                mul_a = MW'(kp_reg);
                mul_b = MW'(e_reg);
            end
            pidtaw_pkg::MS_DIFF:
            begin
                mul_a = MW'(diff);
                mul_b = $signed({{(MW - pidtaw_pkg::PERIOD_W){1'b0}}, pidtaw_pkg::US_PER_S});
            end
            pidtaw_pkg::MS_D:
            begin
                mul_a = MW'(kd_reg);
                mul_b = MW'(r_reg);
            end
            pidtaw_pkg::MS_AVG:
            begin
                // floor of half the sum
                mul_a = MW'($signed(esum[DW:1]));
                mul_b = $signed({{(MW - pidtaw_pkg::PERIOD_W){1'b0}}, period_reg});
            end
            pidtaw_pkg::MS_IT:
            begin
                mul_a = MW'(ki_reg);
                mul_b = tent_sat[MW-1:0];
            end
            pidtaw_pkg::MS_IU:
            begin
                mul_a = MW'(ki_reg);
                mul_b = acc_reg[MW-1:0];
            end
            pidtaw_pkg::MS_REC:
            begin
                // quotient estimate, low by at most one
                mul_a = $signed({1'b0, mag_reg[pidtaw_pkg::MAG_W-1:pidtaw_pkg::REC_LO]});
                mul_b = $signed({1'b0, pidtaw_pkg::US_RECIP});
            end
            pidtaw_pkg::MS_QM:
            begin
                mul_a = $signed({1'b0, prod_reg[QH:pidtaw_pkg::REC_SHIFT]});
                mul_b = $signed({{(MW - pidtaw_pkg::PERIOD_W){1'b0}}, pidtaw_pkg::US_PER_S});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        prod_sh = prod_reg >>> FRAC_BITS;
        sh_t    = prod_sh[SW-1:0];
        lim_s   = $signed({{(SW - pidtaw_pkg::LIMIT_W){1'b0}}, limit_reg});
        ilim    = $signed({{(TW - pidtaw_pkg::LIMIT_W - 1){1'b0}}, limit_reg, 1'b0});
        u_sum   = p_reg + d_reg + sh_t;

        if (quot > R_MAX)
        begin
            r_next = 32'sh7FFF_FFFF;
        end
        else if (quot < -R_MAX - 1)
        begin
            r_next = 32'sh8000_0000;
        end
        else
        begin
            r_next = quot[DW-1:0];
        end

        mag_val = prod_reg[pidtaw_pkg::PROD_W-1] ? XW'(-prod_reg) : prod_reg[XW-1:0];

        // remainder decides the final +1 on the estimate, sign restored after
        rem       = mag_reg - prod_reg[XW-1:0];
        q_inc     = (rem >= XW'(pidtaw_pkg::US_PER_S));
        q_ext     = $signed({{(TW - QW){1'b0}}, q_reg});
        inc_ext   = $signed({{(TW - 1){1'b0}}, q_inc});
        tent_calc = sgn_reg ? TW'(acc_reg) - q_ext - inc_ext
                            : TW'(acc_reg) + q_ext + inc_ext;

        // integral update only while the tentative output is strictly in range
        keep_tent = (u_sum > -lim_s) && (u_sum < lim_s);
        acc_sel   = keep_tent ? tent_reg : TW'(acc_reg);
        if (acc_sel > ilim)
        begin
            acc_next = ilim[AW-1:0];
        end
        else if (acc_sel < -ilim)
        begin
            acc_next = AW'(-ilim);
        end
        else
        begin
            acc_next = acc_sel[AW-1:0];
        end

        limited_next = 1'b0;
        if (u_sum > lim_s)
        begin
            drive_next   = lim_s[DW-1:0];
            limited_next = 1'b1;
        end
        else if (u_sum < -lim_s)
        begin
            drive_next   = DW'(-lim_s);
            limited_next = 1'b1;
        end
        else
        begin
            drive_next = u_sum[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg     <= '0;
            ki_reg     <= '0;
            kd_reg     <= '0;
            period_reg <= '0;
            limit_reg  <= pidtaw_pkg::limit_reset(FRAC_BITS);
            acc_reg    <= '0;
            last_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    pidtaw_pkg::REG_KP:     kp_reg     <= cfg_data;
                    pidtaw_pkg::REG_KI:     ki_reg     <= cfg_data;
                    pidtaw_pkg::REG_KD:     kd_reg     <= cfg_data;
                    pidtaw_pkg::REG_PERIOD: period_reg <= cfg_data[pidtaw_pkg::PERIOD_W-1:0];
                    pidtaw_pkg::REG_LIMIT:  limit_reg  <= cfg_data[pidtaw_pkg::LIMIT_W-1:0];
                    default:                ;
                endcase
            end
            if (cmd.wr_clr)
            begin
                acc_reg  <= '0;
                last_reg <= '0;
            end
            if (cmd.wr_acc)
            begin
                acc_reg <= acc_next;
            end
            if (cmd.wr_fin)
            begin
                last_reg <= e_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e_reg <= err_sample;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.wr_p)
        begin
            p_reg <= sh_t;
        end
        if (cmd.wr_d)
        begin
            d_reg <= sh_t;
        end
        if (cmd.wr_r)
        begin
            r_reg <= r_next;
        end
        if (cmd.wr_mag)
        begin
            mag_reg <= mag_val;
            sgn_reg <= prod_reg[pidtaw_pkg::PROD_W-1];
        end
        if (cmd.wr_q)
        begin
            q_reg <= prod_reg[QH:pidtaw_pkg::REC_SHIFT];
        end
        if (cmd.wr_tent)
        begin
            tent_reg <= tent_calc;
        end
        if (cmd.wr_fin)
        begin
            drive_reg   <= drive_next;
            limited_reg <= limited_next;
        end
        else if (cmd.wr_clr || cmd.wr_zero)
        begin
            drive_reg   <= '0;
            limited_reg <= 1'b0;
        end
    end

endmodule

// ===== sv/pidtaw_ctrl.sv =====
module pidtaw_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pidtaw_pkg::dp_cmd_t   cmd,
    input  pidtaw_pkg::dp_stat_t  stat
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_ZERO,
        S_MP,
        S_MDIFF,
        S_DSTART1,
        S_DWAIT1,
        S_MD,
        S_MAVG,
        S_MAG,
        S_MREC,
        S_QEST,
        S_QFIX,
        S_MIT,
        S_ACC,
        S_MIU,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = pidtaw_pkg::MS_P;
        state_next     = state_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (op)
                    begin
                        state_next = S_CLR;
                    end
                    else if (stat.period_zero)
                    begin
                        state_next = S_ZERO;
                    end
                    else
                    begin
                        state_next = S_MP;
                    end
                end
            end
            S_CLR:
            begin
                if (out_free)
                begin
                    cmd.wr_clr     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_ZERO:
            begin
                if (out_free)
                begin
                    cmd.wr_zero    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_MP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pidtaw_pkg::MS_P;
                state_next  = S_MDIFF;
            end
            S_MDIFF:
            begin
                cmd.wr_p    = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pidtaw_pkg::MS_DIFF;
                state_next  = S_DSTART1;
            end
            S_DSTART1:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT1;
            end
            S_DWAIT1:
            begin
                if (!stat.div_busy)
                begin
                    cmd.wr_r   = 1'b1;
                    state_next = S_MD;
                end
            end
            S_MD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pidtaw_pkg::MS_D;
                state_next  = S_MAVG;
            end
            S_MAVG:
            begin
                cmd.wr_d    = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pidtaw_pkg::MS_AVG;
                state_next  = S_MAG;
            end
            S_MAG:
            begin
                cmd.wr_mag = 1'b1;
                state_next = S_MREC;
            end
            S_MREC:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pidtaw_pkg::MS_REC;
                state_next  = S_QEST;
            end
            S_QEST:
            begin
                cmd.wr_q    = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pidtaw_pkg::MS_QM;
                state_next  = S_QFIX;
            end
            S_QFIX:
            begin
                cmd.wr_tent = 1'b1;
                state_next  = S_MIT;
            end
            S_MIT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pidtaw_pkg::MS_IT;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.wr_acc = 1'b1;
                state_next = S_MIU;
            end
            S_MIU:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pidtaw_pkg::MS_IU;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.wr_fin     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/pid_trapezoid_antiwindup.sv =====
// clear op or zero period: the clear or zero state sets drive valid once the output is free;
// control step: one 54-step division by the period on the radix-2 divider
// plus a run of states on the shared 34x34 multiplier for the products, the reciprocal divide by 1e6
// and the integral update
// a new item is accepted only in idle, after the last one has finished; the next item computes while a result waits
// reset: gains and period zero, limit 1000.0, integral and previous error zero
module pid_trapezoid_antiwindup
#(
    parameter int FRAC_BITS = pidtaw_pkg::FRAC_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  op,
    input  logic signed [pidtaw_pkg::DATA_W-1:0]  err_sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pidtaw_pkg::DATA_W-1:0]  drive,
    output logic                                  limited,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pidtaw_pkg::IDX_W-1:0]          cfg_index,
    input  logic [pidtaw_pkg::DATA_W-1:0]         cfg_data
);

    pidtaw_pkg::dp_cmd_t  cmd;
    pidtaw_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    pidtaw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    pidtaw_dp
    #(
        .FRAC_BITS (FRAC_BITS)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .err_sample (err_sample),
        .drive      (drive),
        .limited    (limited)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef enum logic {OP_STEP = 1'b0, OP_CLEAR = 1'b1} pid_op_t;

    class pid_scoreboard;
        longint kp, ki, kd, period, lim;
        longint acc, prev_err;
        longint drive_q[$];
        bit     lim_q[$];
        int     mismatches;
        int     checked;

        function new();
            kp = 0; ki = 0; kd = 0; period = 0;
            lim = 1000 << FRAC;
            acc = 0; prev_err = 0;
            mismatches = 0; checked = 0;
        endfunction

        function void write_reg(logic [pidtaw_pkg::IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                pidtaw_pkg::REG_KP:     kp = longint'(signed'(data));
                pidtaw_pkg::REG_KI:     ki = longint'(signed'(data));
                pidtaw_pkg::REG_KD:     kd = longint'(signed'(data));
                pidtaw_pkg::REG_PERIOD: period = longint'(data[pidtaw_pkg::PERIOD_W-1:0]);
                pidtaw_pkg::REG_LIMIT:  lim = longint'(data[pidtaw_pkg::LIMIT_W-1:0]);
                default:    ;
            endcase
        endfunction

        function longint clip(longint x, longint lo, longint hi);
            if (x < lo)
            begin
                return lo;
            end
            if (x > hi)
            begin
                return hi;
            end
            return x;
        endfunction

        // full-width product then floor shift
        function longint qmul(longint a, longint b);
            logic signed [127:0] pr;
            pr = 128'(signed'(a)) * 128'(signed'(b));
            pr = pr >>> FRAC;
            return longint'(pr);
        endfunction

        function void note_input(pid_op_t op, logic signed [31:0] err);
            longint e, p, r, d, avg, upd, tent, ts, ut, u;
            bit     lf;
            if (op == OP_CLEAR)
            begin
                acc = 0; prev_err = 0;
                drive_q.push_back(0); lim_q.push_back(0);
                return;
            end
            if (period == 0)
            begin
                drive_q.push_back(0); lim_q.push_back(0);
                return;
            end
            e = longint'(err);
            p = qmul(kp, e);
            r = clip(((e - prev_err) * 1000000) / period, -64'sd2147483648, 64'sd2147483647);
            d = qmul(kd, r);
            avg = (e + prev_err) >>> 1;
            upd = (avg * period) / 1000000;
            tent = acc + upd;
            ts = clip(tent, -64'sd4294967295, 64'sd4294967295);
            ut = p + qmul(ki, ts) + d;
            if (ut > -lim && ut < lim)
            begin
                acc = tent;
            end
            acc = clip(acc, -2 * lim, 2 * lim);
            u = p + qmul(ki, acc) + d;
            lf = 0;
            if (u > lim)
            begin
                u = lim; lf = 1;
            end
            else if (u < -lim)
            begin
                u = -lim; lf = 1;
            end
            prev_err = e;
            drive_q.push_back(u); lim_q.push_back(lf);
        endfunction

        function void check_result(logic signed [31:0] drv, logic lf);
            longint      exp_full;
            logic [31:0] exp_d;
            bit          exp_l;
            if (drive_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result drive=%0d limited=%0b", drv, lf);
                end
                return;
            end
            exp_full = drive_q.pop_front();
            exp_d = exp_full[31:0];
            exp_l = lim_q.pop_front();
            checked++;
            if (exp_d !== drv || exp_l !== lf)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch #%0d: drive exp %0d got %0d, limited exp %0b got %0b",
                             checked, signed'(exp_d), drv, exp_l, lf);
                end
            end
        endfunction
    endclass

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_ready;
    logic                                 op;
    logic signed [pidtaw_pkg::DATA_W-1:0] err_sample;
    logic                                 out_valid;
    logic                                 out_ready;
    logic signed [pidtaw_pkg::DATA_W-1:0] drive;
    logic                                 limited;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [pidtaw_pkg::IDX_W-1:0]         cfg_index;
    logic [pidtaw_pkg::DATA_W-1:0]        cfg_data;

    pid_scoreboard pid_sb;
    bit            calm_tail = 0;
    int            idle_cycles = 0;
    int            step_count = 0;
    int            clear_count = 0;
    int            sat_count = 0;

    pid_trapezoid_antiwindup uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .err_sample(err_sample),
        .out_valid(out_valid), .out_ready(out_ready), .drive(drive), .limited(limited),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // receiver with random stall bursts
    initial
    begin
        int stall;
        out_ready = 1'b0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                pid_sb.check_result(drive, limited);
                if (limited)
                begin
                    sat_count++;
                end
            end
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else if (!calm_tail && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 9) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("FAIL pid_trapezoid_antiwindup");
            $finish;
        end
    end

    task automatic write_cfg(logic [pidtaw_pkg::IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        pid_sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(pid_op_t o, logic [31:0] e);
        int gap;
        if (!calm_tail && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= o;
        err_sample <= e;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pid_sb.note_input(o, e);
        if (o == OP_CLEAR)
        begin
            clear_count++;
        end
        else
        begin
            step_count++;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pid_sb.drive_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (130) @(posedge clk);
    endtask

    task automatic set_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                           logic [31:0] per, logic [31:0] lim);
        write_cfg(pidtaw_pkg::REG_KP, kp);
        write_cfg(pidtaw_pkg::REG_KI, ki);
        write_cfg(pidtaw_pkg::REG_KD, kd);
        write_cfg(pidtaw_pkg::REG_PERIOD, per);
        write_cfg(pidtaw_pkg::REG_LIMIT, lim);
    endtask

    function automatic logic [31:0] rand_err(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            default: return 32'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    initial
    begin
        logic [31:0] extremes [8];
        int          mode;
        pid_sb      = new();
        rst_n = 1'b0;
        in_valid = 1'b0; op = 1'b0; err_sample = '0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero period gives zero drive
        send_item(OP_STEP, 32'h0001_0000);
        send_item(OP_STEP, 32'h8000_0000);
        drain();

        extremes = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
                     32'h0000_0001, 32'h0001_0000, 32'hffff_0000, 32'h5555_aaaa};
        set_all(32'h0001_0000, 32'h0000_8000, 32'h0000_0100, 1000, 32'd65536000);
        foreach (extremes[i])
        begin
            send_item(OP_STEP, extremes[i]);
        end
        send_item(OP_CLEAR, 32'h7fff_ffff);
        send_item(OP_STEP, 32'h0010_0000);
        drain();
        // extreme gains, period, limit
        set_all(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hfffff, 32'h3fff_ffff);
        foreach (extremes[i])
        begin
            send_item(OP_STEP, extremes[i]);
        end
        drain();
        set_all(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1, 1);
        send_item(OP_STEP, 32'h7fff_ffff);
        send_item(OP_STEP, 32'h8000_0000);
        send_item(OP_CLEAR, 32'h0);
        send_item(OP_STEP, 32'h1234_5678);
        drain();
        write_cfg(3'd7, 32'hdead_beef);
        write_cfg(pidtaw_pkg::REG_LIMIT, 32'h0);
        send_item(OP_STEP, 32'h0100_0000);
        send_item(OP_STEP, 32'h0);
        drain();

        // random phases, each with its own settings
        for (int ph = 0; ph < 14; ph++)
        begin
            if (ph == 13)
            begin
                calm_tail = 1;
            end
            if ($urandom_range(0, 2) == 0)
            begin
                set_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            end
            else
            begin
                set_all(32'($urandom_range(0, 262144)), 32'($urandom_range(0, 131072)),
                        32'($urandom_range(0, 4096)), 32'($urandom_range(0, 20000)),
                        32'($urandom_range(1, 32'h3fff_ffff)));
            end
            mode = $urandom_range(0, 2);
            for (int k = 0; k < 125; k++)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    send_item(OP_CLEAR, $urandom());
                end
                else
                begin
                    send_item(OP_STEP, rand_err(mode));
                end
            end
            drain();
        end

        $display("covered %0d control steps and %0d clears over 19 gain/period/limit settings",
                 step_count, clear_count);
        $display("%0d results came out limited, %0d checked", sat_count, pid_sb.checked);
        if (pid_sb.mismatches == 0 && pid_sb.drive_q.size() == 0)
        begin
            $display("PASS pid_trapezoid_antiwindup");
        end
        else
        begin
            $display("%0d mismatches", pid_sb.mismatches);
            $display("FAIL pid_trapezoid_antiwindup");
        end
        $finish;
    end
endmodule
